// ===== rtl/core/iatv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iatv_pkg
// Shared types, character codes and classifiers for the address text checker.
// ----------------------------------------------------------------------------
package iatv_pkg;

   localparam int CharWidth    = 8;
   localparam int VerdictWidth = 2;

   // character codes
   localparam logic [CharWidth-1:0] CharDot   = 8'h2E;
   localparam logic [CharWidth-1:0] CharColon = 8'h3A;
   localparam logic [CharWidth-1:0] CharZero  = 8'h30;
   localparam logic [CharWidth-1:0] CharNine  = 8'h39;
   localparam logic [CharWidth-1:0] CharLowA  = 8'h61;
   localparam logic [CharWidth-1:0] CharLowF  = 8'h66;
   localparam logic [CharWidth-1:0] CharUpA   = 8'h41;
   localparam logic [CharWidth-1:0] CharUpF   = 8'h46;

   // verdict codes
   localparam logic [VerdictWidth-1:0] VerdictNone = 2'd0;
   localparam logic [VerdictWidth-1:0] VerdictIpv4 = 2'd1;
   localparam logic [VerdictWidth-1:0] VerdictIpv6 = 2'd2;

   // dotted-decimal limits
   localparam logic [2:0] DotSepsNeeded = 3'd3;
   localparam logic [2:0] DotSepsMax    = 3'd4;
   localparam logic [1:0] DotLenMax     = 2'd3;
   localparam logic [9:0] DotValueMax   = 10'd255;

   // hex limits
   localparam logic [3:0] HexSepsNeeded = 4'd7;
   localparam logic [3:0] HexSepsMax    = 4'd8;
   localparam logic [2:0] HexLenMax     = 3'd4;

   // one character moving into the checkers
   typedef struct packed {
      logic                 fire;
      logic                 last;
      logic [CharWidth-1:0] code;
   } step_type;

   function automatic logic is_dec(input logic [CharWidth-1:0] c);
      is_dec = (c >= CharZero) && (c <= CharNine);
   endfunction

   function automatic logic is_hex(input logic [CharWidth-1:0] c);
      is_hex = is_dec(c) || ((c >= CharLowA) && (c <= CharLowF))
               || ((c >= CharUpA) && (c <= CharUpF));
   endfunction

endpackage

// ===== rtl/core/iatv_dotted_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iatv_dotted_check
// Running dotted-decimal check: four groups of 1..3 digits, no leading zero,
// each at most 255. Reports pass for the string closed by the current word.
// ----------------------------------------------------------------------------
module iatv_dotted_check (
   input  logic               clock,
   input  logic               reset,
   input  iatv_pkg::step_type step,
   output logic               pass
);
   import iatv_pkg::*;

   logic [2:0] seps_ff, seps_in;
   logic [1:0] len_ff, len_in;
   logic       first_zero_ff, first_zero_in;
   logic [9:0] value_ff, value_in;
   logic       ok_ff, ok_in;
   logic [3:0] digit;
   logic [9:0] value_next;

   assign digit      = step.code[3:0];
   assign value_next = value_ff * 10'd10 + {6'd0, digit};

   // next group state for this character
   always_comb begin
      seps_in       = seps_ff;
      len_in        = len_ff;
      first_zero_in = first_zero_ff;
      value_in      = value_ff;
      ok_in         = ok_ff;
      if (step.code == CharDot) begin
         if (len_ff == 2'd0) ok_in = 1'b0;
         if (seps_ff >= DotSepsNeeded) ok_in = 1'b0;
         if (seps_ff < DotSepsMax) seps_in = seps_ff + 3'd1;
         len_in        = 2'd0;
         first_zero_in = 1'b0;
         value_in      = 10'd0;
      end else if (is_dec(step.code)) begin
         if (len_ff >= DotLenMax) begin
            ok_in = 1'b0;
         end else begin
            if (len_ff == 2'd0) begin
               first_zero_in = (digit == 4'd0);
            end else if (first_zero_ff) begin
               ok_in = 1'b0;
            end
            value_in = value_next;
            if (value_next > DotValueMax) ok_in = 1'b0;
            len_in = len_ff + 2'd1;
         end
      end else begin
         ok_in = 1'b0;
      end
   end

   assign pass = ok_in && (seps_in == DotSepsNeeded) && (len_in != 2'd0);

   // state update, cleared after the closing word
   always_ff @(posedge clock) begin
      if (reset || (step.fire && step.last)) begin
         seps_ff       <= 3'd0;
         len_ff        <= 2'd0;
         first_zero_ff <= 1'b0;
         value_ff      <= 10'd0;
         ok_ff         <= 1'b1;
      end else if (step.fire) begin
         seps_ff       <= seps_in;
         len_ff        <= len_in;
         first_zero_ff <= first_zero_in;
         value_ff      <= value_in;
         ok_ff         <= ok_in;
      end
   end

endmodule

// ===== rtl/core/iatv_hex_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iatv_hex_check
// Running hex check: eight groups of 1..4 hex digits split by colons. Also
// tracks whether a colon appeared, which selects this check at the end.
// ----------------------------------------------------------------------------
module iatv_hex_check (
   input  logic               clock,
   input  logic               reset,
   input  iatv_pkg::step_type step,
   output logic               pass,
   output logic               colon_any
);
   import iatv_pkg::*;

   logic [3:0] seps_ff, seps_in;
   logic [2:0] len_ff, len_in;
   logic       ok_ff, ok_in;
   logic       colon_ff;
   logic       is_colon;

   assign is_colon = (step.code == CharColon);

   // next group state for this character
   always_comb begin
      seps_in = seps_ff;
      len_in  = len_ff;
      ok_in   = ok_ff;
      if (is_colon) begin
         if (len_ff == 3'd0) ok_in = 1'b0;
         if (seps_ff >= HexSepsNeeded) ok_in = 1'b0;
         if (seps_ff < HexSepsMax) seps_in = seps_ff + 4'd1;
         len_in = 3'd0;
      end else if (is_hex(step.code)) begin
         if (len_ff >= HexLenMax) ok_in = 1'b0;
         else len_in = len_ff + 3'd1;
      end else begin
         ok_in = 1'b0;
      end
   end

   assign pass      = ok_in && (seps_in == HexSepsNeeded) && (len_in != 3'd0);
   assign colon_any = colon_ff || is_colon;

   // state update, cleared after the closing word
   always_ff @(posedge clock) begin
      if (reset || (step.fire && step.last)) begin
         seps_ff  <= 4'd0;
         len_ff   <= 3'd0;
         ok_ff    <= 1'b1;
         colon_ff <= 1'b0;
      end else if (step.fire) begin
         seps_ff  <= seps_in;
         len_ff   <= len_in;
         ok_ff    <= ok_in;
         colon_ff <= colon_any;
      end
   end

endmodule

// ===== rtl/core/ip_address_text_validator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_text_validator
// Checks a character stream for a valid IPv4 or IPv6 address, running both
// checks side by side and choosing by whether a colon was seen.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// req       in         req_valid/stall    req_char_code[7:0], req_last_char
// rsp       out        rsp_valid/stall    rsp_verdict[1:0]
//
// One word per cycle is taken while rsp is not stalled; a word waits in the input
// register, then updates both checkers, and a last-character word then loads
// the verdict register, which drives rsp_valid.
// Reset is synchronous and clears the checkers and both valid flags.
// A stalled rsp word holds; the input register then holds too, and req_stall
// rises only while that input register is full and cannot move on.
// ----------------------------------------------------------------------------
module ip_address_text_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_verdict
);
   import iatv_pkg::*;

   logic                    in_valid_ff;
   logic [CharWidth-1:0]    in_char_ff;
   logic                    in_last_ff;
   logic                    out_valid_ff;
   logic [VerdictWidth-1:0] out_verdict_ff, out_verdict_in;
   logic                    out_free;
   logic                    advance;
   logic                    accept;
   step_type                step;
   logic                    dotted_pass;
   logic                    hex_pass;
   logic                    colon_any;

   // flow control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_last_char;
      end
   end

   assign step = '{fire: advance, last: in_last_ff, code: in_char_ff};

   iatv_dotted_check u_dotted (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .pass  (dotted_pass)
   );

   iatv_hex_check u_hex (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .pass      (hex_pass),
      .colon_any (colon_any)
   );

   // verdict select
   always_comb begin
      out_verdict_in = VerdictNone;
      if (colon_any) begin
         if (hex_pass) out_verdict_in = VerdictIpv6;
      end else begin
         if (dotted_pass) out_verdict_in = VerdictIpv4;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         out_verdict_ff <= out_verdict_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_verdict = out_verdict_ff;

endmodule

// ===== tb/address_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_verdict_checker
// Watches both channels of the address text checker. It keeps its own scan
// state for the dotted-decimal and hex paths, queues the verdict expected at
// each last character and compares every accepted verdict against it.
// ----------------------------------------------------------------------------
module address_verdict_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_verdict,
   output int         error_count,
   output int         pending_count
);
   import iatv_pkg::*;

   typedef struct {
      logic [2:0] dot_seps;
      logic [1:0] dot_len;
      logic       dot_lead_zero;
      logic [9:0] dot_value;
      logic       dot_ok;
      logic [3:0] hex_seps;
      logic [2:0] hex_len;
      logic       hex_ok;
      logic       colon_hit;
   } scan_state_type;

   scan_state_type scan;
   logic [1:0]     expected_verdicts[$];
   int             mismatch_count = 0;
   int             waiting_verdicts = 0;

   assign error_count   = mismatch_count;
   assign pending_count = waiting_verdicts;

   task automatic report_mismatch(input string what);
      $display("%0t MISMATCH %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void clear_scan();
      scan.dot_seps      = '0;
      scan.dot_len       = '0;
      scan.dot_lead_zero = 1'b0;
      scan.dot_value     = '0;
      scan.dot_ok        = 1'b1;
      scan.hex_seps      = '0;
      scan.hex_len       = '0;
      scan.hex_ok        = 1'b1;
      scan.colon_hit     = 1'b0;
   endfunction

   // advance both paths by one character; returns 1 when a verdict is due
   function automatic bit scan_char(input logic [7:0] code, input logic last,
                                    output logic [1:0] verdict);
      int  digit;
      int  next_value;
      bit  dec_digit;
      bit  hex_digit;
      dec_digit = (code >= CharZero) && (code <= CharNine);
      hex_digit = dec_digit || ((code >= CharLowA) && (code <= CharLowF))
                  || ((code >= CharUpA) && (code <= CharUpF));
      digit   = int'(code) - int'(CharZero);
      verdict = VerdictNone;

      if (code == CharColon) scan.colon_hit = 1'b1;

      // dotted-decimal path
      if (code == CharDot) begin
         if (scan.dot_len == 0) scan.dot_ok = 1'b0;
         if (scan.dot_seps >= DotSepsNeeded) scan.dot_ok = 1'b0;
         if (scan.dot_seps < DotSepsMax) scan.dot_seps++;
         scan.dot_len       = '0;
         scan.dot_lead_zero = 1'b0;
         scan.dot_value     = '0;
      end else if (dec_digit) begin
         if (scan.dot_len >= DotLenMax) begin
            scan.dot_ok = 1'b0;
         end else begin
            if (scan.dot_len == 0) scan.dot_lead_zero = (digit == 0);
            else if (scan.dot_lead_zero) scan.dot_ok = 1'b0;
            next_value     = int'(scan.dot_value) * 10 + digit;
            scan.dot_value = next_value[9:0];
            if (next_value > 255) scan.dot_ok = 1'b0;
            scan.dot_len++;
         end
      end else begin
         scan.dot_ok = 1'b0;
      end

      // hex path
      if (code == CharColon) begin
         if (scan.hex_len == 0) scan.hex_ok = 1'b0;
         if (scan.hex_seps >= HexSepsNeeded) scan.hex_ok = 1'b0;
         if (scan.hex_seps < HexSepsMax) scan.hex_seps++;
         scan.hex_len = '0;
      end else if (hex_digit) begin
         if (scan.hex_len >= HexLenMax) scan.hex_ok = 1'b0;
         else scan.hex_len++;
      end else begin
         scan.hex_ok = 1'b0;
      end

      if (!last) return 1'b0;

      // a colon anywhere selects the hex verdict
      if (scan.colon_hit) begin
         if (scan.hex_ok && scan.hex_seps == HexSepsNeeded && scan.hex_len != 0)
            verdict = VerdictIpv6;
      end else begin
         if (scan.dot_ok && scan.dot_seps == DotSepsNeeded && scan.dot_len != 0)
            verdict = VerdictIpv4;
      end
      clear_scan();
      return 1'b1;
   endfunction

   // predict on accepted chars, compare on accepted verdicts
   always @(posedge clock) begin
      logic [1:0] predicted;
      logic [1:0] oldest;
      if (reset) begin
         clear_scan();
         expected_verdicts.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (scan_char(req_char_code, req_last_char, predicted))
               expected_verdicts.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("verdict %0d with no string pending",
                                         rsp_verdict));
            end else begin
               oldest = expected_verdicts.pop_front();
               if (rsp_verdict !== oldest)
                  report_mismatch($sformatf("verdict got %0d want %0d",
                                            rsp_verdict, oldest));
            end
         end
      end
      waiting_verdicts = expected_verdicts.size();
   end

endmodule

// ===== tb/ip_address_text_validator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_text_validator_tb
// Feeds address strings one character word at a time: a few fixed strings,
// then mostly well-formed IPv4 and IPv6 text with injected faults, plus raw
// byte noise. Both channels idle and stall at random; a separate checker
// predicts and compares every verdict.
// ----------------------------------------------------------------------------
module ip_address_text_validator_tb;
   import iatv_pkg::*;

   localparam int WordTarget  = 800;
   localparam int DrainCycles = 10;
   localparam int LimitNs     = 1_000_000;
   localparam logic [7:0] CharLowG = 8'h67;

   typedef enum int {
      FaultNone,
      FaultEmpty,
      FaultLong,
      FaultLeadZero,
      FaultBigValue,
      FaultForeign,
      FaultCount
   } fault_kind_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_char_code;
   logic       req_last_char;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_verdict;
   int         error_count;
   int         pending_count;

   int         words_sent = 0;
   int         send_quiet = 0;
   int         recv_quiet = 0;
   logic [7:0] text_q[$];

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ip_address_text_validator i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_verdict   (rsp_verdict)
   );

   address_verdict_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_verdict   (rsp_verdict),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // wait length per word, with occasional stretches of back-to-back words
   function automatic int draw_hold(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) quiet_left = $urandom_range(10, 40);
      return $urandom_range(0, 14);
   endfunction

   task automatic put_decimal(input int v);
      if (v >= 100) text_q.push_back(CharZero + 8'(v / 100));
      if (v >= 10) text_q.push_back(CharZero + 8'((v / 10) % 10));
      text_q.push_back(CharZero + 8'(v % 10));
   endtask

   task automatic put_hex_digit();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) text_q.push_back(CharZero + 8'(r));
      else if (r < 16) text_q.push_back(CharLowA + 8'(r - 10));
      else text_q.push_back(CharUpA + 8'(r - 16));
   endtask

   task automatic put_foreign();
      case ($urandom_range(0, 3))
         0: text_q.push_back(8'($urandom_range(0, 255)));
         1: text_q.push_back(CharColon);
         2: text_q.push_back(CharDot);
         default: text_q.push_back(CharLowG);
      endcase
   endtask

   function automatic fault_kind_type pick_fault();
      if ($urandom_range(0, 1) == 0) return FaultNone;
      return fault_kind_type'($urandom_range(int'(FaultEmpty), int'(FaultCount)));
   endfunction

   // dotted-decimal text, at most one faulty group
   task automatic build_dotted();
      fault_kind_type fault;
      int             groups;
      int             fault_at;
      int             g;
      fault    = pick_fault();
      groups   = 4;
      fault_at = $urandom_range(0, 3);
      if (fault == FaultCount) begin
         groups = $urandom_range(1, 7);
         if (groups == 4) groups = 5;
      end
      for (g = 0; g < groups; g++) begin
         if (g > 0) text_q.push_back(CharDot);
         case ((g == fault_at) ? fault : FaultNone)
            FaultEmpty: ;
            FaultLong: begin
               text_q.push_back(CharZero + 8'($urandom_range(0, 9)));
               put_decimal($urandom_range(100, 999));
            end
            FaultLeadZero: begin
               text_q.push_back(CharZero);
               put_decimal($urandom_range(0, 99));
            end
            FaultBigValue: put_decimal($urandom_range(256, 999));
            FaultForeign: begin
               put_foreign();
               put_decimal($urandom_range(0, 255));
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: put_decimal(0);
                  1: put_decimal(255);
                  default: put_decimal($urandom_range(0, 255));
               endcase
            end
         endcase
      end
   endtask

   // hex text with colons, at most one faulty group
   task automatic build_hex();
      fault_kind_type fault;
      int             groups;
      int             fault_at;
      int             g;
      int             n;
      fault    = pick_fault();
      groups   = 8;
      fault_at = $urandom_range(0, 7);
      if (fault == FaultCount) begin
         groups = $urandom_range(1, 10);
         if (groups == 8) groups = 9;
      end
      for (g = 0; g < groups; g++) begin
         if (g > 0) text_q.push_back(CharColon);
         case ((g == fault_at) ? fault : FaultNone)
            FaultEmpty: n = 0;
            FaultLong: n = $urandom_range(5, 6);
            FaultForeign: begin
               put_foreign();
               n = $urandom_range(0, 3);
            end
            default: n = $urandom_range(1, 4);
         endcase
         repeat (n) put_hex_digit();
      end
   endtask

   // raw bytes leaning on digits and separators
   task automatic build_noise();
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(0, 4))
            0: text_q.push_back(8'($urandom_range(0, 255)));
            1: text_q.push_back(CharDot);
            2: text_q.push_back(CharColon);
            3: put_hex_digit();
            default: text_q.push_back(CharZero + 8'($urandom_range(0, 9)));
         endcase
      end
   endtask

   task automatic load_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   // one word per call, held until accepted; returns at the next falling edge
   task automatic send_char(input logic [7:0] code, input logic last);
      int gap;
      gap = draw_hold(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= code;
      req_last_char <= last;
      do @(posedge clock); while (req_stall);
      words_sent++;
      @(negedge clock);
   endtask

   // the character that empties the queue closes the string
   task automatic send_text();
      logic [7:0] code;
      if (text_q.size() == 0) text_q.push_back(CharZero);
      while (text_q.size() > 0) begin
         code = text_q.pop_front();
         send_char(code, text_q.size() == 0);
      end
   endtask

   // stimulus and verdict
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_code = '0;
      req_last_char = 1'b0;
      rsp_stall     = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: top values, both address forms, extreme bytes
      load_text("255.0.19.9");
      send_text();
      load_text("a:B:c:D:e:F:0:9");
      send_text();
      send_char(8'hFF, 1'b1);
      send_char(8'h00, 1'b1);

      while (words_sent < WordTarget) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: build_dotted();
            4, 5, 6: build_hex();
            default: build_noise();
         endcase
         send_text();
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // result side stalls
   initial begin
      int hold;
      wait (reset === 1'b0);
      forever begin
         hold = draw_hold(recv_quiet);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // watchdog
   initial begin
      #(LimitNs);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
